[rtl/core/htfd_pkg.sv]
package htfd_pkg;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [14:0] TEMP_SCALE = 15'd17500;
	localparam logic [13:0] HUMI_SCALE = 14'd10000;
	localparam logic [14:0] TEMP_OFFSET = 15'd4500;

	localparam logic [2:0] POS_TEMP_HI = 3'd0;
	localparam logic [2:0] POS_TEMP_LO = 3'd1;
	localparam logic [2:0] POS_TEMP_CRC = 3'd2;
	localparam logic [2:0] POS_HUMI_HI = 3'd3;
	localparam logic [2:0] POS_HUMI_LO = 3'd4;
	localparam logic [2:0] POS_HUMI_CRC = 3'd5;

	typedef struct packed {
		logic [15:0] temp_word;
		logic [15:0] humi_word;
		logic        temp_ok;
		logic        humi_ok;
	} frame_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

[rtl/core/htfd_front.sv]
module htfd_front
	import htfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       frame_start,
	output logic       push,
	output frame_t     push_frame
);

	logic [2:0]  byte_index_q;
	logic [7:0]  crc_q;
	logic [15:0] temp_word_q;
	logic [15:0] humi_word_q;
	logic        temp_ok_q;

	logic [2:0]  idx;
	logic [2:0]  idx_next;
	logic [7:0]  crc_step;

	assign idx = (frame_start || byte_index_q > POS_HUMI_CRC) ? POS_TEMP_HI : byte_index_q;
	assign idx_next = (idx == POS_HUMI_CRC) ? POS_TEMP_HI : idx + 3'd1;

	always_comb begin
		if (idx == POS_TEMP_HI || idx == POS_HUMI_HI) begin
			crc_step = crc8_byte(CRC_INIT, data_byte);
		end else begin
			crc_step = crc8_byte(crc_q, data_byte);
		end
	end

	assign push = accept && (idx == POS_HUMI_CRC);
	assign push_frame = '{temp_word: temp_word_q, humi_word: humi_word_q,
		temp_ok: temp_ok_q, humi_ok: (crc_q == data_byte)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= POS_TEMP_HI;
			crc_q <= CRC_INIT;
			temp_word_q <= '0;
			humi_word_q <= '0;
			temp_ok_q <= 1'b0;
		end else if (accept) begin
			byte_index_q <= idx_next;
			unique case (idx)
				POS_TEMP_HI: begin
					crc_q <= crc_step;
					temp_word_q[15:8] <= data_byte;
				end
				POS_TEMP_LO: begin
					crc_q <= crc_step;
					temp_word_q[7:0] <= data_byte;
				end
				POS_TEMP_CRC: begin
					temp_ok_q <= (crc_q == data_byte);
					crc_q <= CRC_INIT;
				end
				POS_HUMI_HI: begin
					crc_q <= crc_step;
					humi_word_q[15:8] <= data_byte;
				end
				POS_HUMI_LO: begin
					crc_q <= crc_step;
					humi_word_q[7:0] <= data_byte;
				end
				POS_HUMI_CRC: begin
					crc_q <= CRC_INIT;
				end
				default: begin
					crc_q <= CRC_INIT;
				end
			endcase
		end
	end

endmodule

[rtl/core/htfd_queue.sv]
module htfd_queue
	import htfd_pkg::*;
#(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  frame_t push_frame,
	output logic   full,
	input  logic   pop,
	output logic   not_empty,
	output frame_t pop_frame
);

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	frame_t          mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full = (count_q == CntW'(Depth));
	assign not_empty = (count_q != '0);
	assign pop_frame = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/htfd_back.sv]
module htfd_back
	import htfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               avail,
	input  frame_t             frame,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [14:0] temperature_centi,
	output logic [13:0]        humidity_centi,
	output logic               temp_crc_ok,
	output logic               humi_crc_ok
);

	logic        valid_s1;
	logic [30:0] temp_prod_s1;
	logic [29:0] humi_prod_s1;
	logic        temp_ok_s1;
	logic        humi_ok_s1;
	logic        valid_s2;
	logic        load_s2;
	logic        load_s1;

	assign load_s2 = !valid_s2 || !out_stall;
	assign load_s1 = !valid_s1 || load_s2;
	assign pop = avail && load_s1;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= avail;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			temp_prod_s1 <= 31'(TEMP_SCALE) * 31'(frame.temp_word);
			humi_prod_s1 <= 30'(HUMI_SCALE) * 30'(frame.humi_word);
			temp_ok_s1 <= frame.temp_ok;
			humi_ok_s1 <= frame.humi_ok;
		end
		if (load_s2 && valid_s1) begin
			temperature_centi <= signed'(temp_prod_s1[30:16] - TEMP_OFFSET);
			humidity_centi <= humi_prod_s1[29:16];
			temp_crc_ok <= temp_ok_s1;
			humi_crc_ok <= humi_ok_s1;
		end
	end

endmodule

[rtl/core/humidity_temp_frame_decoder.sv]
// One byte is taken per cycle unless the queue is full; CRC and words update as it is taken.
// The sixth byte pushes the frame into the queue; it then passes stages s1 and s2.
// A queue of QueueDepth frames separates byte intake from the two-stage conversion,
// so input stalls only while that queue is full.
// Reset clears byte position, words, queue and out_valid; CRC is set to CRC_INIT.
module humidity_temp_frame_decoder
	import htfd_pkg::*;
#(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               frame_start,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [14:0] temperature_centi,
	output logic [13:0]        humidity_centi,
	output logic               temp_crc_ok,
	output logic               humi_crc_ok
);

	logic   accept;
	logic   push;
	frame_t push_frame;
	logic   full;
	logic   pop;
	logic   not_empty;
	frame_t pop_frame;

	assign in_stall = full;
	assign accept = in_valid && !full;

	htfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (data_byte),
		.frame_start(frame_start),
		.push       (push),
		.push_frame (push_frame)
	);

	htfd_queue #(
		.Depth(QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_frame(push_frame),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_frame (pop_frame)
	);

	htfd_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.avail            (not_empty),
		.frame            (pop_frame),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.temperature_centi(temperature_centi),
		.humidity_centi   (humidity_centi),
		.temp_crc_ok      (temp_crc_ok),
		.humi_crc_ok      (humi_crc_ok)
	);

endmodule
